// ===== design/itcg_pkg.sv =====
package itcg_pkg;

  // Field widths
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned INTV_W  = 20;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned MAXC_W  = 8;
  localparam int unsigned OUTC_W  = 3;
  localparam int unsigned OMIT_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Divider: dividend is delta plus half an interval, one bit more than a stamp
  localparam int unsigned NUM_W = STAMP_W + 1;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  // Register reset values
  localparam logic [INTV_W-1:0] INTV_RST = INTV_W'(10000);
  localparam logic [TOL_W-1:0]  TOL_RST  = TOL_W'(50);
  localparam logic [MAXC_W-1:0] MAXC_RST = MAXC_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL  = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_MAX_CONCEAL = 2'd2
  } itcg_cfg_idx_e;

  typedef enum logic [OUTC_W-1:0] {
    OUT_FIRST   = 3'd0,
    OUT_NOSTAMP = 3'd1,
    OUT_RESYNC  = 3'd2,
    OUT_WRAP    = 3'd3,
    OUT_CONTIG  = 3'd4,
    OUT_GAP     = 3'd5
  } itcg_outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIV,
    ST_EVAL,
    ST_FIN
  } itcg_state_e;

  // What kind of event is being processed
  typedef enum logic [2:0] {
    KIND_NOSTAMP,
    KIND_ZERO_INTV,
    KIND_FIRST,
    KIND_WRAP,
    KIND_FWD
  } itcg_kind_e;

  typedef struct packed {
    logic busy;
    logic done;
  } itcg_div_stat_t;

endpackage

// ===== design/iso_timestamp_cadence_gap_tracker_top.sv =====
// Flow: an item that needs no division goes through PREP and FIN; a forward timestamp
//   goes through PREP, LOAD, DIV (the bit-serial divider), EVAL and FIN.
// Items: one at a time; the next item is accepted once the previous result is in the
//   output register.
// Reset: rst_ni is asynchronous, active low; clears tracker state and totals and
//   loads interval 10000 us, tolerance 50 us, max conceal 8.
module iso_timestamp_cadence_gap_tracker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [itcg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [itcg_pkg::INTV_W-1:0]        cfg_data_i,
  // input events
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [31:0]                        s_axis_tdata,  // [31:0] stamp
  input  logic                               s_axis_tuser,  // [0] has_stamp
  // results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] omitted_count, [39:8] concealed_total, [71:40] resync_total
  output logic [71:0]                        m_axis_tdata,
  output logic [2:0]                         m_axis_tuser   // [2:0] outcome
);

  // Configuration registers
  logic [itcg_pkg::INTV_W-1:0]  intv_q;
  logic [itcg_pkg::TOL_W-1:0]   tol_q;
  logic [itcg_pkg::MAXC_W-1:0]  maxc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intv_q <= itcg_pkg::INTV_RST;
      tol_q  <= itcg_pkg::TOL_RST;
      maxc_q <= itcg_pkg::MAXC_RST;
    end else if (cfg_we_i) begin
      unique case (itcg_pkg::itcg_cfg_idx_e'(cfg_idx_i))
        itcg_pkg::CFG_INTERVAL:    intv_q <= cfg_data_i;
        itcg_pkg::CFG_TOLERANCE:   tol_q  <= cfg_data_i[itcg_pkg::TOL_W-1:0];
        itcg_pkg::CFG_MAX_CONCEAL: maxc_q <= cfg_data_i[itcg_pkg::MAXC_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  itcg_pkg::itcg_state_e state_q, state_d;
  logic started_q;
  logic [itcg_pkg::STAMP_W-1:0] last_q, unst_q, conc_q, rsync_q;
  logic out_valid_q, out_valid_d;

  // Item registers
  logic                          has_q;
  logic [itcg_pkg::STAMP_W-1:0]  stamp_q;
  itcg_pkg::itcg_kind_e          kind_q;
  logic [itcg_pkg::STAMP_W-1:0]  delta_q;
  logic [itcg_pkg::NUM_W:0]      diff_q;
  logic                          zero_q, err_bad_q;

  // Output registers
  itcg_pkg::itcg_outcome_e       out_outc_q;
  logic [itcg_pkg::OMIT_W-1:0]   out_omit_q;
  logic [itcg_pkg::STAMP_W-1:0]  out_conc_q, out_rsync_q;

  // Divider
  logic                             div_start;
  logic [itcg_pkg::NUM_W-1:0]       div_num, div_quo;
  logic [itcg_pkg::INTV_W-1:0]      div_rem;
  itcg_pkg::itcg_div_stat_t         div_stat;

  assign div_num = {1'b0, delta_q} + itcg_pkg::NUM_W'(intv_q[itcg_pkg::INTV_W-1:1]);

  itcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (intv_q),
    .stat_o (div_stat),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  logic in_fire, commit;

  // FSM outputs
  always_comb begin
    s_axis_tready = (state_q == itcg_pkg::ST_IDLE);
    div_start     = (state_q == itcg_pkg::ST_LOAD);
    commit        = (state_q == itcg_pkg::ST_FIN) && (!out_valid_q || m_axis_tready);
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // FSM next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itcg_pkg::ST_IDLE: if (in_fire) state_d = itcg_pkg::ST_PREP;
      itcg_pkg::ST_PREP: begin
        state_d = itcg_pkg::ST_FIN;
        if (has_q && intv_q != '0 && started_q && stamp_q >= last_q) begin
          state_d = itcg_pkg::ST_LOAD;
        end
      end
      itcg_pkg::ST_LOAD: state_d = itcg_pkg::ST_DIV;
      itcg_pkg::ST_DIV:  if (div_stat.done) state_d = itcg_pkg::ST_EVAL;
      itcg_pkg::ST_EVAL: state_d = itcg_pkg::ST_FIN;
      itcg_pkg::ST_FIN:  if (commit) state_d = itcg_pkg::ST_IDLE;
      default:           state_d = itcg_pkg::ST_IDLE;
    endcase
  end

  // Event classification
  itcg_pkg::itcg_kind_e kind_d;
  always_comb begin
    priority if (!has_q)           kind_d = itcg_pkg::KIND_NOSTAMP;
    else if (intv_q == '0)         kind_d = itcg_pkg::KIND_ZERO_INTV;
    else if (!started_q)           kind_d = itcg_pkg::KIND_FIRST;
    else if (stamp_q < last_q)     kind_d = itcg_pkg::KIND_WRAP;
    else                           kind_d = itcg_pkg::KIND_FWD;
  end

  // Distance of the delta from the nearest grid multiple is |rem - interval/2|
  logic [itcg_pkg::INTV_W-1:0] half, err;
  assign half = {1'b0, intv_q[itcg_pkg::INTV_W-1:1]};
  assign err  = (div_rem >= half) ? (div_rem - half) : (half - div_rem);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      has_q   <= s_axis_tuser;
      stamp_q <= s_axis_tdata;
    end
    if (state_q == itcg_pkg::ST_PREP) begin
      kind_q  <= kind_d;
      delta_q <= stamp_q - last_q;
    end
    if (state_q == itcg_pkg::ST_EVAL) begin
      // events - delivered, with delivered = unstamped + 1
      diff_q    <= {1'b0, div_quo} - {2'b00, unst_q} - 1'b1;
      zero_q    <= (div_quo == '0);
      err_bad_q <= (err > itcg_pkg::INTV_W'(tol_q));
    end
  end

  // Final decision
  itcg_pkg::itcg_outcome_e outc;
  logic [itcg_pkg::OMIT_W-1:0] omit;
  logic omit_big;
  assign omit_big = (diff_q[itcg_pkg::NUM_W-1:itcg_pkg::OMIT_W] != '0)
                 || (diff_q[itcg_pkg::OMIT_W-1:0] > maxc_q);

  always_comb begin
    omit = '0;
    unique case (kind_q)
      itcg_pkg::KIND_NOSTAMP:   outc = itcg_pkg::OUT_NOSTAMP;
      itcg_pkg::KIND_ZERO_INTV: outc = itcg_pkg::OUT_RESYNC;
      itcg_pkg::KIND_FIRST:     outc = itcg_pkg::OUT_FIRST;
      itcg_pkg::KIND_WRAP:      outc = itcg_pkg::OUT_WRAP;
      itcg_pkg::KIND_FWD: begin
        priority if (zero_q || diff_q[itcg_pkg::NUM_W] || err_bad_q || omit_big) begin
          outc = itcg_pkg::OUT_RESYNC;
        end else if (diff_q[itcg_pkg::OMIT_W-1:0] == '0) begin
          outc = itcg_pkg::OUT_CONTIG;
        end else begin
          outc = itcg_pkg::OUT_GAP;
          omit = diff_q[itcg_pkg::OMIT_W-1:0];
        end
      end
      default:                  outc = itcg_pkg::OUT_RESYNC;
    endcase
  end

  logic [itcg_pkg::STAMP_W-1:0] conc_d, rsync_d;
  assign conc_d  = conc_q + itcg_pkg::STAMP_W'(omit);
  assign rsync_d = (outc == itcg_pkg::OUT_RESYNC) ? rsync_q + 1'b1 : rsync_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Tracker state and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itcg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      last_q      <= '0;
      unst_q      <= '0;
      conc_q      <= '0;
      rsync_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        conc_q  <= conc_d;
        rsync_q <= rsync_d;
        unique case (kind_q)
          itcg_pkg::KIND_NOSTAMP: begin
            if (started_q && !(&unst_q)) unst_q <= unst_q + 1'b1;
          end
          itcg_pkg::KIND_ZERO_INTV: ;
          itcg_pkg::KIND_FIRST, itcg_pkg::KIND_WRAP, itcg_pkg::KIND_FWD: begin
            started_q <= 1'b1;
            last_q    <= stamp_q;
            unst_q    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_outc_q  <= outc;
      out_omit_q  <= omit;
      out_conc_q  <= conc_d;
      out_rsync_q <= rsync_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_outc_q;
  assign m_axis_tdata  = {out_rsync_q, out_conc_q, out_omit_q};

`ifndef ASSERT_OFF
  // divider only runs while the FSM waits for it
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == itcg_pkg::ST_DIV))
    else $error("divider busy outside of division state");

  // resync total moves by at most one per committed item
  a_rsync_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (rsync_q == $past(rsync_q)) || (rsync_q == $past(rsync_q) + 1'b1))
    else $error("resync total jumped");

  // only a gap carries a nonzero omitted count
  a_gap_omit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == itcg_pkg::OUT_GAP) == (m_axis_tdata[7:0] != '0)))
    else $error("omitted count does not match outcome");

  // no item is taken while one is in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input accepted while busy");
`endif

endmodule

// ===== design/itcg_div.sv =====
// Restoring divider, one quotient bit per cycle.
module itcg_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [itcg_pkg::NUM_W-1:0]       num_i,
  input  logic [itcg_pkg::INTV_W-1:0]      den_i,
  output itcg_pkg::itcg_div_stat_t         stat_o,
  output logic [itcg_pkg::NUM_W-1:0]       quo_o,
  output logic [itcg_pkg::INTV_W-1:0]      rem_o
);

  logic                              busy_q, busy_d;
  logic [itcg_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [itcg_pkg::INTV_W-1:0]       rem_q, rem_d;
  logic [itcg_pkg::NUM_W-1:0]        sh_q, sh_d;
  logic [itcg_pkg::INTV_W:0]         trial;
  logic                              qbit;
  logic                              last_step;

  // Trial subtract of the divisor from the partial remainder
  assign trial     = {rem_q, sh_q[itcg_pkg::NUM_W-1]} - {1'b0, den_i};
  assign qbit      = ~trial[itcg_pkg::INTV_W];
  assign last_step = busy_q && (cnt_q == itcg_pkg::CNT_W'(itcg_pkg::NUM_W - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      sh_d   = num_i;
    end else if (busy_q) begin
      // quotient bits shift in as dividend bits shift out
      sh_d  = {sh_q[itcg_pkg::NUM_W-2:0], qbit};
      rem_d = qbit ? trial[itcg_pkg::INTV_W-1:0]
                   : {rem_q[itcg_pkg::INTV_W-2:0], sh_q[itcg_pkg::NUM_W-1]};
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = last_step;
  assign quo_o       = sh_q;
  assign rem_o       = rem_q;

endmodule

// ===== tb/gap_tracker_checker.sv =====
module gap_tracker_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] stamp
  input  logic        s_axis_tuser,   // [0] has_stamp
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] omitted_count, [39:8] concealed_total, [71:40] resync_total
  input  logic [71:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,   // [2:0] outcome
  output int          fail_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    itcg_pkg::itcg_outcome_e outcome;
    logic [7:0]    omitted;
    logic [31:0]   concealed;
    logic [31:0]   resyncs;
  } cadence_result_t;

  // Shadow registers
  logic [19:0] interval;
  logic [15:0] tolerance;
  logic [7:0]  max_conceal;

  // Shadow tracker state
  logic        started;
  logic [31:0] last_stamp;
  logic [31:0] unstamped;
  logic [31:0] concealed_sum;
  logic [31:0] resync_sum;

  cadence_result_t expected_results[$];
  cadence_result_t want;

  // Classify one event and advance the shadow state
  function automatic cadence_result_t classify_event(input logic has, input logic [31:0] ts);
    logic [63:0] delivered, delta, events, nearest, err, omitted;
    cadence_result_t r;
    r.omitted = '0;
    if (!has) begin
      if (started && unstamped != 32'hFFFF_FFFF) unstamped = unstamped + 32'd1;
      r.outcome = itcg_pkg::OUT_NOSTAMP;
    end else if (interval == '0) begin
      resync_sum = resync_sum + 32'd1;
      r.outcome  = itcg_pkg::OUT_RESYNC;
    end else if (!started) begin
      started    = 1'b1;
      last_stamp = ts;
      unstamped  = '0;
      r.outcome  = itcg_pkg::OUT_FIRST;
    end else if (ts < last_stamp) begin
      last_stamp = ts;
      unstamped  = '0;
      r.outcome  = itcg_pkg::OUT_WRAP;
    end else begin
      delivered  = {32'd0, unstamped} + 64'd1;
      delta      = {32'd0, ts - last_stamp};
      last_stamp = ts;
      unstamped  = '0;
      // round to the nearest grid multiple
      events  = (delta + {45'd0, interval[19:1]}) / {44'd0, interval};
      nearest = events * {44'd0, interval};
      err     = (delta > nearest) ? delta - nearest : nearest - delta;
      omitted = events - delivered;
      if (events == 64'd0 || events < delivered || err > {48'd0, tolerance} ||
          omitted > {56'd0, max_conceal}) begin
        resync_sum = resync_sum + 32'd1;
        r.outcome  = itcg_pkg::OUT_RESYNC;
      end else if (omitted == 64'd0) begin
        r.outcome = itcg_pkg::OUT_CONTIG;
      end else begin
        concealed_sum = concealed_sum + omitted[31:0];
        r.outcome     = itcg_pkg::OUT_GAP;
        r.omitted     = omitted[7:0];
      end
    end
    r.concealed = concealed_sum;
    r.resyncs   = resync_sum;
    return r;
  endfunction

  // Track config writes, predict on accepted inputs, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval      = itcg_pkg::INTV_RST;
      tolerance     = itcg_pkg::TOL_RST;
      max_conceal   = itcg_pkg::MAXC_RST;
      started       = 1'b0;
      last_stamp    = '0;
      unstamped     = '0;
      concealed_sum = '0;
      resync_sum    = '0;
      fail_count_o  = 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          itcg_pkg::CFG_INTERVAL:    interval    = cfg_data_i;
          itcg_pkg::CFG_TOLERANCE:   tolerance   = cfg_data_i[15:0];
          itcg_pkg::CFG_MAX_CONCEAL: max_conceal = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: outcome %0d data %h", $time, m_axis_tuser,
                   m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser !== want.outcome) begin
            $display("%0t: outcome: expected %0d, actual %0d", $time, want.outcome,
                     m_axis_tuser);
            fail_count_o++;
          end
          if (m_axis_tdata[7:0] !== want.omitted) begin
            $display("%0t: omitted_count: expected %0d, actual %0d", $time, want.omitted,
                     m_axis_tdata[7:0]);
            fail_count_o++;
          end
          if (m_axis_tdata[39:8] !== want.concealed) begin
            $display("%0t: concealed_total: expected %0d, actual %0d", $time,
                     want.concealed, m_axis_tdata[39:8]);
            fail_count_o++;
          end
          if (m_axis_tdata[71:40] !== want.resyncs) begin
            $display("%0t: resync_total: expected %0d, actual %0d", $time, want.resyncs,
                     m_axis_tdata[71:40]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(classify_event(s_axis_tuser, s_axis_tdata));
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [19:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] stamp
  logic        s_axis_tuser;   // [0] has_stamp
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] omitted_count, [39:8] concealed_total, [71:40] resync_total
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;   // [2:0] outcome

  int fail_count;
  int pending;

  // Stimulus knobs and the generator's view of the block
  int          send_idle_pct;
  int          recv_stall_pct;
  int          cur_interval;
  int          cur_tol;
  int          cur_maxc;
  logic [31:0] cur_stamp;
  int          sent;
  int          quiet_cycles;

  iso_timestamp_cadence_gap_tracker_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  gap_tracker_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #1 clk_i = ~clk_i;

  // Receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one event; entered and left at a falling edge
  task automatic push_event(input logic has, input logic [31:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ts;
    s_axis_tuser  <= has;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (has) cur_stamp = ts;
    sent++;
  endtask

  // Stop sending until every outstanding result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input itcg_pkg::itcg_cfg_idx_e idx, input logic [19:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input int intv, input int tol, input int maxc);
    cur_interval = intv;
    cur_tol      = tol;
    cur_maxc     = maxc;
    write_reg(itcg_pkg::CFG_INTERVAL, 20'(intv));
    write_reg(itcg_pkg::CFG_TOLERANCE, 20'(tol));
    write_reg(itcg_pkg::CFG_MAX_CONCEAL, 20'(maxc));
  endtask

  // One random burst: mostly on-grid runs, plus noise and broken cadence
  task automatic random_burst();
    int     pick, half, jlim, jitter, omit, delivered, n;
    longint step;
    pick = $urandom_range(99);
    if (pick < 70) begin
      case ($urandom_range(3))
        0:       omit = 0;
        1:       omit = cur_maxc + $urandom_range(1);
        default: omit = $urandom_range((cur_maxc + 1 < 10) ? cur_maxc + 1 : 10);
      endcase
      delivered = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1;
      n         = omit + delivered;
      half      = (cur_interval == 0) ? 1000 : cur_interval / 2;
      jlim      = ((cur_tol < half) ? cur_tol : half) + 2;
      jitter    = ($urandom_range(3) == 0) ? int'($urandom_range(2 * jlim)) - jlim
                                           : int'($urandom_range(2 * (jlim - 2))) - (jlim - 2);
      step      = longint'(n) * cur_interval + jitter;
      repeat (delivered - 1) push_event(1'b0, $urandom);
      push_event(1'b1, cur_stamp + 32'(step));
    end else if (pick < 80) begin
      push_event(1'b0, $urandom);
    end else if (pick < 88) begin
      push_event(1'b1, cur_stamp - 32'($urandom_range(1, 50000)));
    end else if (pick < 94) begin
      push_event(1'b1, $urandom);
    end else begin
      push_event(1'b1, 32'hFFFF_FFFF - 32'($urandom_range(0, 3 * cur_interval)));
    end
  endtask

  task automatic run_phase(input int ph, input int quota);
    case (ph % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
    case (ph)
      0: apply_settings(10000, 50, 8);
      1: apply_settings(1, 0, 255);
      2: apply_settings(1048575, 65535, 0);
      3: apply_settings(7, 3, 4);
      4: apply_settings($urandom_range(2, 2000), $urandom_range(0, 300), $urandom_range(20));
      5: apply_settings(125, 0, 255);
      6: apply_settings($urandom_range(1, 1048575), $urandom_range(0, 65535),
                        $urandom_range(0, 255));
      default: apply_settings(0, $urandom_range(0, 65535), $urandom_range(0, 255));
    endcase
    sent = 0;
    while (sent < quota) begin
      random_burst();
      // occasional full drain mid-phase
      if ($urandom_range(49) == 0) drain();
    end
    drain();
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = itcg_pkg::CFG_INTERVAL;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_stamp      = '0;
    sent           = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Zero interval before the first stamp: resync, tracker stays unstarted
    apply_settings(0, 50, 8);
    push_event(1'b1, 32'h1234_5678);
    push_event(1'b0, 32'h0000_0000);
    drain();

    // Directed cadence cases at the default grid
    apply_settings(10000, 50, 8);
    push_event(1'b0, 32'hFFFF_FFFF);   // unstamped before start
    push_event(1'b1, 32'd1000);        // first
    push_event(1'b1, 32'd11000);       // on grid
    push_event(1'b1, 32'd21050);       // error right at tolerance
    push_event(1'b1, 32'd31101);       // one past tolerance
    push_event(1'b1, 32'd61101);       // two missing
    push_event(1'b0, 32'd0);
    push_event(1'b1, 32'd81101);       // unstamped one fills the gap
    push_event(1'b0, 32'd0);
    push_event(1'b0, 32'd0);
    push_event(1'b1, 32'd101101);      // more delivered than grid slots
    push_event(1'b1, 32'd105101);      // rounds to zero events
    push_event(1'b1, 32'd105101);      // repeated stamp
    push_event(1'b1, 32'd110101);      // exactly half an interval
    push_event(1'b1, 32'd210101);      // one over the conceal bound
    push_event(1'b1, 32'd300101);      // conceal bound exactly
    push_event(1'b1, 32'd300100);      // backward stamp
    push_event(1'b1, 32'hFFFF_FFFF);   // largest stamp, long forward delta
    push_event(1'b1, 32'h0000_0000);   // wrap to zero
    push_event(1'b0, 32'hFFFF_FFFF);   // unstamped after start
    push_event(1'b1, 32'd9999);        // short delta with a pending unstamped one
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      run_phase(ph, (ph == 7) ? 40 : 180);
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
